// ----- rtl/core/mls_pkg.sv -----
// ============================================================================
// mls_pkg
// Shared constants, types and helpers of the MAC learning switch.
// ============================================================================
package mls_pkg;

    // Switch geometry
    localparam int NUM_PORTS    = 5;
    localparam int MAC_BITS     = 16;
    localparam int TABLE_DEPTH  = 1 << MAC_BITS;

    // Fixed field widths
    localparam int PORT_W       = 3;    // ingress port field
    localparam int ENTRY_PORT_W = 4;    // port stored in a table entry
    localparam int MASK_W       = 5;    // egress mask and port_connected
    localparam int MAC_W        = 16;   // MAC fields on the stream

    localparam logic [MASK_W-1:0]   CFG_RESET = 5'd31;
    localparam logic [MAC_BITS-1:0] BCAST_MAC = {MAC_BITS{1'b1}};

    // Result of one table lookup, after forwarding.
    typedef struct packed {
        logic                    hit;
        logic [ENTRY_PORT_W-1:0] port;
    } lookup_t;

    // Bits of the mask that belong to a port that exists.
    function automatic logic [MASK_W-1:0] port_mask();
        logic [MASK_W-1:0] m;
        m = '0;
        for (int p = 0; p < MASK_W; p++)
        begin
            m[p] = (p < NUM_PORTS);
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/mls_table.sv -----
// ============================================================================
// mls_table
// Learning table: one synchronous memory indexed by MAC, with a clearing
// sweep after reset and forwarding of a write that meets a read.
// ============================================================================
module mls_table (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rd_en,
    input  logic [mls_pkg::MAC_BITS-1:0]           rd_addr,
    input  logic                                   wr_en,
    input  logic [mls_pkg::MAC_BITS-1:0]           wr_addr,
    input  logic [mls_pkg::ENTRY_PORT_W-1:0]       wr_port,
    output logic                                   ready,
    output mls_pkg::lookup_t                       lookup
);

    localparam int ENTRY_W = mls_pkg::ENTRY_PORT_W + 1;

    logic [ENTRY_W-1:0] mem [mls_pkg::TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [mls_pkg::MAC_BITS-1:0]     clr_addr_reg, clr_addr_next;
    logic                             clr_done_reg, clr_done_next;
    logic                             fwd_reg, fwd_next;
    logic [mls_pkg::ENTRY_PORT_W-1:0] fwd_port_reg, fwd_port_next;

    logic                             mem_we;
    logic [mls_pkg::MAC_BITS-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]               mem_wdata;

    // The sweep owns the write port until every entry holds "invalid".
    always_comb
    begin
        if (!clr_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = {1'b1, wr_port};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            clr_done_next = (clr_addr_reg == {mls_pkg::MAC_BITS{1'b1}});
        end
    end

    // A read that lands on the entry being written in the same cycle would
    // return the old value, so the new port is carried alongside.
    always_comb
    begin
        fwd_next      = fwd_reg;
        fwd_port_next = fwd_port_reg;
        if (rd_en)
        begin
            fwd_next      = wr_en && (wr_addr == rd_addr);
            fwd_port_next = wr_port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_done_reg <= clr_done_next;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_port_reg <= fwd_port_next;
    end

    assign ready       = clr_done_reg;
    assign lookup.hit  = fwd_reg ? 1'b1 : rd_data_reg[ENTRY_W-1];
    assign lookup.port = fwd_reg ? fwd_port_reg : rd_data_reg[mls_pkg::ENTRY_PORT_W-1:0];

endmodule

// ----- rtl/core/mls_decide.sv -----
// ============================================================================
// mls_decide
// Forwarding decision: flood or unicast mask from the lookup result.
// ============================================================================
module mls_decide (
    input  logic                              accepted,
    input  logic [mls_pkg::PORT_W-1:0]        ingress_port,
    input  logic                              same_mac,
    input  logic                              dest_bcast,
    input  mls_pkg::lookup_t                  lookup,
    input  logic [mls_pkg::MASK_W-1:0]        connected,
    output logic [mls_pkg::MASK_W-1:0]        egress_mask,
    output logic                              flooded
);

    mls_pkg::lookup_t                 entry;
    logic [mls_pkg::MASK_W-1:0]       ingress_bit;
    logic [mls_pkg::MASK_W-1:0]       learned_bit;

    // When source and destination match, the entry just learned applies.
    always_comb
    begin
        if (same_mac)
        begin
            entry.hit  = 1'b1;
            entry.port = {1'b0, ingress_port};
        end
        else
        begin
            entry = lookup;
        end
    end

    always_comb
    begin
        for (int p = 0; p < mls_pkg::MASK_W; p++)
        begin
            ingress_bit[p] = (ingress_port == mls_pkg::PORT_W'(p));
            learned_bit[p] = (entry.port == mls_pkg::ENTRY_PORT_W'(p)) && (p < mls_pkg::NUM_PORTS);
        end
    end

    always_comb
    begin
        egress_mask = '0;
        flooded     = 1'b0;
        if (accepted)
        begin
            if (dest_bcast || !entry.hit)
            begin
                flooded     = 1'b1;
                egress_mask = connected & ~ingress_bit;
            end
            else
            begin
                egress_mask = connected & learned_bit;
            end
        end
    end

endmodule

// ----- rtl/core/mac_learning_switch.sv -----
// ============================================================================
// mac_learning_switch
// Ethernet learning bridge: learns source MAC to port, forwards by dest MAC.
// ============================================================================
// Path: a frame beat accepted on the slave side is held in stage one while its
// destination entry is read from the table, and its decision then goes into
// the output register that drives the master side.
// Throughput: one frame per cycle unless m_tready holds the output back; the single
// table memory port pair allows one read (destination) and one write (source) each cycle.
// Reset: port_connected returns to all ones, and a clearing sweep walks the
// 65536 table entries, one per cycle, with s_tready low until it finishes.
// ============================================================================
module mac_learning_switch (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: port_connected
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,

    // Frame headers in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] ingress_port, [18:3] source_mac,
                                   // [34:19] dest_mac, [39:35] zero

    // Forwarding decisions out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [4:0] egress_mask, [5] flooded,
                                   // [6] accepted, [7] zero
);

    localparam int MB = mls_pkg::MAC_BITS;
    localparam int PW = mls_pkg::PORT_W;
    localparam int MW = mls_pkg::MASK_W;

    // Unpack the slave beat.
    logic [PW-1:0] in_port;
    logic [MB-1:0] in_src;
    logic [MB-1:0] in_dst;

    assign in_port = s_tdata[PW-1:0];
    assign in_src  = s_tdata[PW +: MB];
    assign in_dst  = s_tdata[PW + mls_pkg::MAC_W +: MB];

    // Configuration register; only existing ports are ever considered.
    logic [MW-1:0] conn_reg, conn_next;
    logic [MW-1:0] conn_eff;

    assign conn_next = cfg_we ? cfg_wdata : conn_reg;
    assign conn_eff  = conn_reg & mls_pkg::port_mask();

    // Stage one holds the frame while its destination entry is being read.
    logic          v1_reg, v1_next;
    logic          acc1_reg, acc1_next;
    logic [PW-1:0] port1_reg, port1_next;
    logic [MB-1:0] src1_reg, src1_next;
    logic [MB-1:0] dst1_reg, dst1_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [MW-1:0] mask_reg, mask_next;
    logic          flood_reg, flood_next;
    logic          acc_reg, acc_next;

    logic             tbl_ready;
    mls_pkg::lookup_t lookup;
    logic             in_fire;
    logic             adv;
    logic             in_acc;
    logic             tbl_we;
    logic [MW-1:0]    dec_mask;
    logic             dec_flood;

    // Stage one moves into the output register whenever that register is
    // empty or is being drained in this cycle.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = tbl_ready && (!v1_reg || adv);
    assign in_fire  = s_tvalid && s_tready;

    // A frame is handled only on a connected port that exists.
    assign in_acc = (int'(in_port) < mls_pkg::NUM_PORTS) && conn_eff[in_port];

    // Learning write happens once, as the frame leaves stage one.
    assign tbl_we = v1_reg && adv && acc1_reg;

    mls_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (in_dst),
        .wr_en   (tbl_we),
        .wr_addr (src1_reg),
        .wr_port ({1'b0, port1_reg}),
        .ready   (tbl_ready),
        .lookup  (lookup)
    );

    mls_decide u_decide (
        .accepted     (acc1_reg),
        .ingress_port (port1_reg),
        .same_mac     (src1_reg == dst1_reg),
        .dest_bcast   (dst1_reg == mls_pkg::BCAST_MAC),
        .lookup       (lookup),
        .connected    (conn_eff),
        .egress_mask  (dec_mask),
        .flooded      (dec_flood)
    );

    always_comb
    begin
        v1_next    = v1_reg;
        acc1_next  = acc1_reg;
        port1_next = port1_reg;
        src1_next  = src1_reg;
        dst1_next  = dst1_reg;
        if (in_fire)
        begin
            v1_next    = 1'b1;
            acc1_next  = in_acc;
            port1_next = in_port;
            src1_next  = in_src;
            dst1_next  = in_dst;
        end
        else if (adv)
        begin
            v1_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        mask_next      = mask_reg;
        flood_next     = flood_reg;
        acc_next       = acc_reg;
        if (adv)
        begin
            out_valid_next = v1_reg;
            mask_next      = dec_mask;
            flood_next     = dec_flood;
            acc_next       = acc1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg      <= mls_pkg::CFG_RESET;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            conn_reg      <= conn_next;
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc1_reg  <= acc1_next;
        port1_reg <= port1_next;
        src1_reg  <= src1_next;
        dst1_reg  <= dst1_next;
        mask_reg  <= mask_next;
        flood_reg <= flood_next;
        acc_reg   <= acc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, acc_reg, flood_reg, mask_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // No frame may enter while the clearing sweep still owns the table.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_ready |-> !s_tready)
        else $error("frame accepted during table clear");

    // A learning write comes only from a handled frame leaving stage one.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (v1_reg && acc1_reg && tbl_ready))
        else $error("table write without a handled frame");

    // A frame leaving stage one is in the output register in the next cycle.
    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv) |=> out_valid_reg)
        else $error("frame lost between stage one and output");

    // A frame that was not handled goes nowhere and is not flooded.
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !acc_reg) |-> (mask_reg == '0 && !flood_reg))
        else $error("rejected frame has a forwarding decision");

    // A unicast decision names at most one port.
    a_unicast_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !flood_reg) |-> $onehot0(mask_reg))
        else $error("unicast mask has more than one port");

endmodule
